// ===== rtl/stt_pkg.sv =====
// Shared types, constants and character classes for the source text tokenizer.
package stt_pkg;

	typedef enum logic [4:0] {
		S_IDLE, S_IDENT, S_ZERO, S_INT, S_INT_DOT, S_FLOAT, S_FLOAT_DOT, S_HEX,
		S_STR, S_CHR, S_COMMENT, S_SLASH, S_DOT1, S_DOT2,
		S_LT, S_GT, S_EQ, S_MINUS, S_BANG, S_AMP, S_BAR
	} scan_state_t;

	typedef struct packed {
		logic [5:0]  lex_kind;
		logic [31:0] start_offset;
		logic [31:0] start_line;
		logic [31:0] start_column;
		logic [31:0] lex_length;
		logic [1:0]  error_code;
		logic        last;
	} result_t;

	typedef struct packed {
		logic idle;
		logic halted;
	} front_status_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_BYTE  = 2'd1;
	localparam logic [1:0] ERR_UNTERM = 2'd2;
	localparam logic [1:0] ERR_NUMBER = 2'd3;

	localparam logic [5:0] K_IDENT  = 6'd0;
	localparam logic [5:0] K_INT    = 6'd1;
	localparam logic [5:0] K_FLOAT  = 6'd2;
	localparam logic [5:0] K_HEX    = 6'd3;
	localparam logic [5:0] K_STRING = 6'd4;
	localparam logic [5:0] K_CHAR   = 6'd5;
	localparam logic [5:0] K_SLASH  = 6'd33;
	localparam logic [5:0] K_DOT    = 6'd34;
	localparam logic [5:0] K_DOT2   = 6'd35;
	localparam logic [5:0] K_DOT3   = 6'd36;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SL    = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7c;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return c == CH_UNDER || is_alpha(c) || is_digit(c);
	endfunction

	// 0 when the byte is not a one-byte operator
	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h2b: k = 6'd6;
			8'h2a: k = 6'd7;
			8'h25: k = 6'd8;
			8'h3a: k = 6'd9;
			8'h3b: k = 6'd10;
			8'h2c: k = 6'd11;
			8'h28: k = 6'd12;
			8'h29: k = 6'd13;
			8'h7b: k = 6'd14;
			8'h7d: k = 6'd15;
			8'h5b: k = 6'd16;
			8'h5d: k = 6'd17;
			8'h23: k = 6'd18;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	function automatic scan_state_t pair_state(input logic [7:0] c);
		scan_state_t s;
		case (c)
			CH_LT:    s = S_LT;
			CH_GT:    s = S_GT;
			CH_EQ:    s = S_EQ;
			CH_MINUS: s = S_MINUS;
			CH_BANG:  s = S_BANG;
			CH_AMP:   s = S_AMP;
			CH_BAR:   s = S_BAR;
			default:  s = S_IDLE;
		endcase
		return s;
	endfunction

	function automatic logic is_pair(input scan_state_t s);
		return s == S_LT || s == S_GT || s == S_EQ || s == S_MINUS ||
			s == S_BANG || s == S_AMP || s == S_BAR;
	endfunction

	function automatic logic [7:0] pair_second(input scan_state_t s);
		logic [7:0] c;
		case (s)
			S_MINUS: c = CH_GT;
			S_AMP:   c = CH_AMP;
			S_BAR:   c = CH_BAR;
			default: c = CH_EQ;
		endcase
		return c;
	endfunction

	function automatic logic [5:0] pair_kind(input scan_state_t s);
		logic [5:0] k;
		case (s)
			S_LT:    k = 6'd19;
			S_GT:    k = 6'd21;
			S_EQ:    k = 6'd23;
			S_MINUS: k = 6'd25;
			S_BANG:  k = 6'd27;
			S_AMP:   k = 6'd29;
			S_BAR:   k = 6'd31;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/stt_front.sv =====
// Scanner front end: one byte per cycle while accept is high, state update and up to two results.
module stt_front import stt_pkg::*; #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          mode,
	input  logic [7:0]    char_code,
	output logic [1:0]    res_cnt,
	output result_t       res0,
	output result_t       res1,
	output front_status_t status
);

	localparam int P = POSITION_WIDTH;
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};
	localparam logic [P-1:0] POS_ONE = {{(P-1){1'b0}}, 1'b1};
	localparam logic [P-1:0] POS_TWO = {{(P-2){1'b0}}, 2'b10};
	localparam logic [P-1:0] POS_THREE = {{(P-2){1'b0}}, 2'b11};

	typedef struct packed {
		logic         v;
		logic [5:0]   kind;
		logic [1:0]   err;
		logic [P-1:0] o;
		logic [P-1:0] l;
		logic [P-1:0] c;
		logic [P-1:0] len;
	} emit_t;

	function automatic logic [P-1:0] sat_inc(input logic [P-1:0] x);
		return (x == POS_MAX) ? POS_MAX : x + POS_ONE;
	endfunction

	function automatic logic [P-1:0] sat_add(input logic [P-1:0] a, input logic [P-1:0] b);
		logic [P:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[P] ? POS_MAX : s[P-1:0];
	endfunction

	function automatic result_t to_res(input emit_t e, input logic lst);
		result_t r;
		r.lex_kind     = e.kind;
		r.start_offset = 32'(e.o);
		r.start_line   = 32'(e.l);
		r.start_column = 32'(e.c);
		r.lex_length   = 32'(e.len);
		r.error_code   = e.err;
		r.last         = lst;
		return r;
	endfunction

	scan_state_t st_q, st_n;
	logic [P-1:0] tso_q, tsl_q, tsc_q, tlen_q, co_q, cl_q, cc_q;
	logic [P-1:0] tso_n, tsl_n, tsc_n, tlen_n, co_n, cl_n, cc_n;
	logic halted_q, halted_n;

	emit_t ea, eb;
	scan_state_t s;
	logic again, after, hlt;
	logic [P-1:0] body;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			tso_q    <= '0;
			tsl_q    <= POS_ONE;
			tsc_q    <= '0;
			tlen_q   <= '0;
			co_q     <= '0;
			cl_q     <= POS_ONE;
			cc_q     <= '0;
			halted_q <= 1'b0;
		end else begin
			st_q     <= st_n;
			tso_q    <= tso_n;
			tsl_q    <= tsl_n;
			tsc_q    <= tsc_n;
			tlen_q   <= tlen_n;
			co_q     <= co_n;
			cl_q     <= cl_n;
			cc_q     <= cc_n;
			halted_q <= halted_n;
		end
	end

	always_comb begin
		st_n = st_q;
		tso_n = tso_q; tsl_n = tsl_q; tsc_n = tsc_q; tlen_n = tlen_q;
		co_n = co_q; cl_n = cl_q; cc_n = cc_q;
		halted_n = halted_q;
		ea = '0;
		eb = '0;
		s = st_q;
		again = 1'b0;
		after = 1'b0;
		hlt = 1'b0;
		body = '0;
		// token emit from the start registers by default
		ea.o = tso_q; ea.l = tsl_q; ea.c = tsc_q; ea.len = tlen_q;
		eb.o = co_q; eb.l = cl_q; eb.c = cc_q;
		if (accept && mode) begin
			if (!halted_q) begin
				case (st_q)
					S_IDENT: begin ea.v = 1'b1; ea.kind = K_IDENT; end
					S_ZERO, S_INT: begin ea.v = 1'b1; ea.kind = K_INT; end
					S_INT_DOT, S_FLOAT: begin ea.v = 1'b1; ea.kind = K_FLOAT; end
					S_FLOAT_DOT: begin
						ea.v = 1'b1; ea.err = ERR_NUMBER; ea.len = '0;
						ea.o = co_q; ea.l = cl_q; ea.c = cc_q;
					end
					S_HEX: begin
						ea.v = 1'b1;
						if (tlen_q == '0) begin
							ea.err = ERR_NUMBER; ea.o = co_q; ea.l = cl_q; ea.c = cc_q;
						end else begin
							ea.kind = K_HEX;
						end
					end
					S_STR, S_CHR: begin
						ea.v = 1'b1; ea.err = ERR_UNTERM; ea.len = '0;
						ea.o = co_q; ea.l = cl_q; ea.c = cc_q;
					end
					S_SLASH: begin ea.v = 1'b1; ea.kind = K_SLASH; ea.len = POS_ONE; end
					S_DOT1: begin ea.v = 1'b1; ea.kind = K_DOT; ea.len = POS_ONE; end
					S_DOT2: begin ea.v = 1'b1; ea.kind = K_DOT2; ea.len = POS_TWO; end
					default: begin
						if (is_pair(st_q)) begin
							ea.v = 1'b1; ea.kind = pair_kind(st_q); ea.len = POS_ONE;
						end
					end
				endcase
			end
			st_n = S_IDLE;
			tso_n = '0; tsl_n = POS_ONE; tsc_n = '0; tlen_n = '0;
			co_n = '0; cl_n = POS_ONE; cc_n = '0;
			halted_n = 1'b0;
		end else if (accept && !halted_q) begin
			// states that only hand the byte on without emitting
			if (s == S_ZERO && char_code != CH_X) s = S_INT;
			if (s == S_INT_DOT && char_code != CH_DOT) s = S_FLOAT;
			st_n = s;
			case (s)
				S_IDLE: again = 1'b1;
				S_IDENT: begin
					if (is_ident(char_code)) tlen_n = sat_inc(tlen_q);
					else begin ea.v = 1'b1; ea.kind = K_IDENT; again = 1'b1; end
				end
				S_ZERO: begin st_n = S_HEX; tlen_n = '0; after = 1'b1; end
				S_INT, S_FLOAT: begin
					if (is_digit(char_code)) tlen_n = sat_inc(tlen_q);
					else if (char_code == CH_DOT) begin
						tlen_n = sat_inc(tlen_q);
						st_n = (s == S_INT) ? S_INT_DOT : S_FLOAT_DOT;
					end else begin
						ea.v = 1'b1; ea.kind = (s == S_INT) ? K_INT : K_FLOAT;
						again = 1'b1;
					end
				end
				S_INT_DOT, S_FLOAT_DOT: begin
					if (char_code == CH_DOT) begin
						body = (tlen_q == '0) ? '0 : tlen_q - POS_ONE;
						ea.v = 1'b1; ea.kind = (s == S_INT_DOT) ? K_INT : K_FLOAT;
						ea.len = body;
						tso_n = sat_add(tso_q, body);
						tsc_n = sat_add(tsc_q, body);
						tlen_n = POS_TWO;
						st_n = S_DOT2;
					end else begin
						ea.v = 1'b1; ea.err = ERR_NUMBER; ea.len = '0;
						ea.o = co_q; ea.l = cl_q; ea.c = cc_q;
						hlt = 1'b1;
					end
				end
				S_HEX: begin
					if (is_alpha(char_code) || is_digit(char_code)) tlen_n = sat_inc(tlen_q);
					else if (tlen_q == '0) begin
						ea.v = 1'b1; ea.err = ERR_NUMBER; ea.len = '0;
						ea.o = co_q; ea.l = cl_q; ea.c = cc_q;
						hlt = 1'b1;
					end else begin
						ea.v = 1'b1; ea.kind = K_HEX; again = 1'b1;
					end
				end
				S_STR, S_CHR: begin
					if (char_code == ((s == S_STR) ? CH_DQ : CH_SQ)) begin
						ea.v = 1'b1; ea.kind = (s == S_STR) ? K_STRING : K_CHAR;
						st_n = S_IDLE;
					end else tlen_n = sat_inc(tlen_q);
				end
				S_COMMENT: if (char_code == CH_LF) st_n = S_IDLE;
				S_SLASH: begin
					if (char_code == CH_SL) st_n = S_COMMENT;
					else begin
						ea.v = 1'b1; ea.kind = K_SLASH; ea.len = POS_ONE; again = 1'b1;
					end
				end
				S_DOT1: begin
					if (char_code == CH_DOT) st_n = S_DOT2;
					else begin
						ea.v = 1'b1; ea.kind = K_DOT; ea.len = POS_ONE; again = 1'b1;
					end
				end
				S_DOT2: begin
					ea.v = 1'b1;
					st_n = S_IDLE;
					if (char_code == CH_DOT) begin
						ea.kind = K_DOT3; ea.len = POS_THREE;
					end else begin
						ea.kind = K_DOT2; ea.len = POS_TWO; again = 1'b1;
					end
				end
				default: begin
					if (char_code == pair_second(s)) begin
						ea.v = 1'b1; ea.kind = pair_kind(s) + 6'd1; ea.len = POS_TWO;
						st_n = S_IDLE;
					end else begin
						ea.v = 1'b1; ea.kind = pair_kind(s); ea.len = POS_ONE;
						again = 1'b1;
					end
				end
			endcase
			// byte seen again from the idle state
			if (again) begin
				st_n = S_IDLE;
				if (char_code == CH_SPACE || char_code == CH_TAB ||
					char_code == CH_LF || char_code == CH_CR) begin
					st_n = S_IDLE;
				end else if (single_kind(char_code) != 6'd0) begin
					eb.v = 1'b1; eb.kind = single_kind(char_code); eb.len = POS_ONE;
				end else begin
					tso_n = co_q; tsl_n = cl_q; tsc_n = cc_q;
					tlen_n = POS_ONE;
					if (pair_state(char_code) != S_IDLE) st_n = pair_state(char_code);
					else if (char_code == CH_SL) st_n = S_SLASH;
					else if (char_code == CH_DOT) st_n = S_DOT1;
					else if (char_code == CH_DQ || char_code == CH_SQ) begin
						st_n = (char_code == CH_DQ) ? S_STR : S_CHR;
						tlen_n = '0;
						after = 1'b1;
					end
					else if (char_code == CH_UNDER || is_alpha(char_code)) st_n = S_IDENT;
					else if (char_code == CH_ZERO) st_n = S_ZERO;
					else if (is_digit(char_code)) st_n = S_INT;
					else begin
						eb.v = 1'b1; eb.err = ERR_BYTE; eb.len = '0;
						hlt = 1'b1;
					end
				end
			end
			if (hlt) halted_n = 1'b1;
			else begin
				co_n = sat_inc(co_q);
				if (char_code == CH_LF) begin
					cl_n = sat_inc(cl_q); cc_n = '0;
				end else cc_n = sat_inc(cc_q);
				if (after) begin
					tso_n = co_n; tsl_n = cl_n; tsc_n = cc_n;
				end
			end
		end
	end

	always_comb begin
		res_cnt = {1'b0, ea.v} + {1'b0, eb.v};
		if (ea.v) begin
			res0 = to_res(ea, !eb.v);
			res1 = to_res(eb, 1'b1);
		end else begin
			res0 = to_res(eb, 1'b1);
			res1 = to_res(eb, 1'b1);
		end
	end

	assign status.idle   = (st_q == S_IDLE);
	assign status.halted = halted_q;

endmodule

// ===== rtl/stt_queue.sv =====
// Result queue: takes up to two results a cycle, delivers one.
module stt_queue import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        wr_cnt,
	input  result_t           wr0,
	input  result_t           wr1,
	input  logic              pop,
	output logic              empty,
	output logic              full,
	output result_t           rd,
	output logic [QCNT_W-1:0] count
);

	result_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(wr_cnt);
			rp_q  <= rp_q + QPTR_W'(do_pop);
			cnt_q <= cnt_q + QCNT_W'(wr_cnt) - QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) mem_q[wp_q] <= wr0;
		if (wr_cnt == 2'd2) mem_q[wp_q + QPTR_W'(1)] <= wr1;
	end

	assign rd    = mem_q[rp_q];
	assign empty = (cnt_q == '0);
	// room for the two results one byte may cause
	assign full  = (cnt_q > QCNT_W'(QDEPTH - 2));
	assign count = cnt_q;

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
// Takes one text byte (or an end-of-text marker) per cycle and gives tokens with
// kind, start position and length through a four-entry result queue. The scanner
// handles each byte as it is accepted, updates its state and may produce up to
// two results; the scanner stalls (full) only when the queue holds three or more
// results, i.e. lacks room for two. Bytes go in back to back at one per cycle as
// long as results are popped at least as fast as they are made; the output side
// delivers one result per cycle, so a run of bytes that each make two results
// is held to that pace. A byte's results are written to the queue as the byte is
// accepted and can be popped in the next cycle, the second behind the first.
module source_text_tokenizer import stt_pkg::*; #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  char_code,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  lex_kind,
	output logic [31:0] start_offset,
	output logic [31:0] start_line,
	output logic [31:0] start_column,
	output logic [31:0] lex_length,
	output logic [1:0]  error_code,
	output logic        last
);

	logic accept;
	logic [1:0] res_cnt;
	result_t res0, res1, rd;
	front_status_t fe_status;
	logic [QCNT_W-1:0] q_count;

	assign accept = push && !full;

	stt_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (mode),
		.char_code (char_code),
		.res_cnt   (res_cnt),
		.res0      (res0),
		.res1      (res1),
		.status    (fe_status)
	);

	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_cnt (res_cnt),
		.wr0    (res0),
		.wr1    (res1),
		.pop    (pop),
		.empty  (empty),
		.full   (full),
		.rd     (rd),
		.count  (q_count)
	);

	assign lex_kind     = rd.lex_kind;
	assign start_offset = rd.start_offset;
	assign start_line   = rd.start_line;
	assign start_column = rd.start_column;
	assign lex_length   = rd.lex_length;
	assign error_code   = rd.error_code;
	assign last         = rd.last;

`ifndef SYNTH
	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode |=> fe_status.idle && !fe_status.halted)
		else $error("scanner not restarted after end of text");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fe_status.halted && !(accept && mode) |-> res_cnt == 2'd0)
		else $error("results produced while halted");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for source_text_tokenizer: directed and random token streams against a predictor.
module testbench;
	import stt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       mode;
		logic [7:0] code;
	} text_item_t;

	localparam logic [31:0] POS_TOP = 32'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk, arst_n;
	logic        push, full, mode, empty, pop, last;
	logic [7:0]  char_code;
	logic [5:0]  lex_kind;
	logic [31:0] start_offset, start_line, start_column, lex_length;
	logic [1:0]  error_code;

	text_item_t  text_q[$];
	result_t     token_q[$];
	int          mismatches = 0;
	int          cycles = 0;
	int          push_wait = 0, pop_wait = 0;
	bit          no_idle = 0;

	// predictor state
	scan_state_t lx_state;
	logic [31:0] tok_off, tok_line, tok_col, tok_len;
	logic [31:0] cur_off, cur_line, cur_col;
	bit          lx_halted;
	int          n_out;

	source_text_tokenizer uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.char_code(char_code), .empty(empty), .pop(pop), .lex_kind(lex_kind),
		.start_offset(start_offset), .start_line(start_line), .start_column(start_column),
		.lex_length(lex_length), .error_code(error_code), .last(last)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] sat1(input logic [31:0] x);
		return (x == POS_TOP) ? x : x + 32'd1;
	endfunction

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? POS_TOP : s[31:0];
	endfunction

	function automatic bit alpha_c(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_c(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] op1_kind(input logic [7:0] c);
		case (c)
			"+": return 6'd6;   "*": return 6'd7;   "%": return 6'd8;
			":": return 6'd9;   ";": return 6'd10;  ",": return 6'd11;
			"(": return 6'd12;  ")": return 6'd13;  "{": return 6'd14;
			"}": return 6'd15;  "[": return 6'd16;  "]": return 6'd17;
			"#": return 6'd18;
			default: return 6'd0;
		endcase
	endfunction

	function automatic scan_state_t pair_open(input logic [7:0] c);
		case (c)
			"<": return S_LT;    ">": return S_GT;   "=": return S_EQ;
			"-": return S_MINUS; "!": return S_BANG; "&": return S_AMP;
			"|": return S_BAR;
			default: return S_IDLE;
		endcase
	endfunction

	function automatic logic [5:0] pair_base(input scan_state_t s);
		case (s)
			S_LT: return 6'd19;    S_GT: return 6'd21;   S_EQ: return 6'd23;
			S_MINUS: return 6'd25; S_BANG: return 6'd27; S_AMP: return 6'd29;
			default: return 6'd31;
		endcase
	endfunction

	function automatic logic [7:0] pair_tail(input scan_state_t s);
		case (s)
			S_MINUS: return ">";
			S_AMP: return "&";
			S_BAR: return "|";
			default: return "=";
		endcase
	endfunction

	task automatic lexer_reset();
		lx_state = S_IDLE;
		tok_off = 0; tok_line = 1; tok_col = 0; tok_len = 0;
		cur_off = 0; cur_line = 1; cur_col = 0;
		lx_halted = 0;
	endtask

	task automatic add_token(input logic [5:0] k, input logic [31:0] o, input logic [31:0] l,
			input logic [31:0] c, input logic [31:0] len, input logic [1:0] e);
		result_t r;
		if (n_out >= 2)
			return;
		r.lex_kind = k; r.start_offset = o; r.start_line = l; r.start_column = c;
		r.lex_length = len; r.error_code = e; r.last = 0;
		token_q.push_back(r);
		n_out++;
	endtask

	task automatic add_at_start(input logic [5:0] k, input logic [31:0] len);
		add_token(k, tok_off, tok_line, tok_col, len, ERR_NONE);
	endtask

	task automatic flush_pending();
		case (lx_state)
			S_LT, S_GT, S_EQ, S_MINUS, S_BANG, S_AMP, S_BAR:
				add_at_start(pair_base(lx_state), 1);
			S_IDENT: add_at_start(K_IDENT, tok_len);
			S_ZERO, S_INT: add_at_start(K_INT, tok_len);
			S_INT_DOT, S_FLOAT: add_at_start(K_FLOAT, tok_len);
			S_FLOAT_DOT: add_token(0, cur_off, cur_line, cur_col, 0, ERR_NUMBER);
			S_HEX:
				if (tok_len == 0)
					add_token(0, cur_off, cur_line, cur_col, 0, ERR_NUMBER);
				else
					add_at_start(K_HEX, tok_len);
			S_STR, S_CHR: add_token(0, cur_off, cur_line, cur_col, 0, ERR_UNTERM);
			S_SLASH: add_at_start(K_SLASH, 1);
			S_DOT1: add_at_start(K_DOT, 1);
			S_DOT2: add_at_start(K_DOT2, 2);
			default: ;
		endcase
	endtask

	task automatic tokenize(input logic m, input logic [7:0] c);
		logic [31:0] po, pl, pc, body;
		bit after, again;
		scan_state_t s;
		po = cur_off; pl = cur_line; pc = cur_col;
		after = 0; again = 1;
		n_out = 0;
		if (m) begin
			if (!lx_halted)
				flush_pending();
			lexer_reset();
		end else if (!lx_halted) begin
			while (again && !lx_halted) begin
				s = lx_state;
				again = 0;
				case (s)
					S_LT, S_GT, S_EQ, S_MINUS, S_BANG, S_AMP, S_BAR: begin
						if (c == pair_tail(s)) begin
							add_at_start(pair_base(s) + 6'd1, 2);
						end else begin
							add_at_start(pair_base(s), 1);
							again = 1;
						end
						lx_state = S_IDLE;
					end
					S_IDLE: begin
						if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
						end else if (op1_kind(c) != 0) begin
							add_token(op1_kind(c), po, pl, pc, 1, ERR_NONE);
						end else begin
							tok_off = po; tok_line = pl; tok_col = pc;
							tok_len = 1;
							if (pair_open(c) != S_IDLE) lx_state = pair_open(c);
							else if (c == "/") lx_state = S_SLASH;
							else if (c == ".") lx_state = S_DOT1;
							else if (c == CH_DQ || c == CH_SQ) begin
								lx_state = (c == CH_DQ) ? S_STR : S_CHR;
								tok_len = 0;
								after = 1;
							end else if (c == "_" || alpha_c(c)) lx_state = S_IDENT;
							else if (c == "0") lx_state = S_ZERO;
							else if (digit_c(c)) lx_state = S_INT;
							else begin
								add_token(0, po, pl, pc, 0, ERR_BYTE);
								lx_halted = 1;
							end
						end
					end
					S_IDENT:
						if (c == "_" || alpha_c(c) || digit_c(c)) tok_len = sat1(tok_len);
						else begin
							add_at_start(K_IDENT, tok_len);
							lx_state = S_IDLE; again = 1;
						end
					S_ZERO:
						if (c == "x") begin
							lx_state = S_HEX; tok_len = 0; after = 1;
						end else begin
							lx_state = S_INT; again = 1;
						end
					S_INT, S_FLOAT:
						if (digit_c(c)) tok_len = sat1(tok_len);
						else if (c == ".") begin
							tok_len = sat1(tok_len);
							lx_state = (s == S_INT) ? S_INT_DOT : S_FLOAT_DOT;
						end else begin
							add_at_start((s == S_INT) ? K_INT : K_FLOAT, tok_len);
							lx_state = S_IDLE; again = 1;
						end
					S_INT_DOT, S_FLOAT_DOT:
						if (c == ".") begin
							// "1..": number ends before the range operator
							body = (tok_len != 0) ? tok_len - 1 : 0;
							add_at_start((s == S_INT_DOT) ? K_INT : K_FLOAT, body);
							tok_off = sat_sum(tok_off, body);
							tok_col = sat_sum(tok_col, body);
							tok_len = 2;
							lx_state = S_DOT2;
						end else if (s == S_INT_DOT) begin
							lx_state = S_FLOAT; again = 1;
						end else begin
							add_token(0, po, pl, pc, 0, ERR_NUMBER);
							lx_halted = 1;
						end
					S_HEX:
						if (alpha_c(c) || digit_c(c)) tok_len = sat1(tok_len);
						else if (tok_len == 0) begin
							add_token(0, po, pl, pc, 0, ERR_NUMBER);
							lx_halted = 1;
						end else begin
							add_at_start(K_HEX, tok_len);
							lx_state = S_IDLE; again = 1;
						end
					S_STR, S_CHR:
						if (c == ((s == S_STR) ? CH_DQ : CH_SQ)) begin
							add_at_start((s == S_STR) ? K_STRING : K_CHAR, tok_len);
							lx_state = S_IDLE;
						end else tok_len = sat1(tok_len);
					S_COMMENT:
						if (c == CH_LF) lx_state = S_IDLE;
					S_SLASH:
						if (c == "/") lx_state = S_COMMENT;
						else begin
							add_at_start(K_SLASH, 1);
							lx_state = S_IDLE; again = 1;
						end
					S_DOT1:
						if (c == ".") lx_state = S_DOT2;
						else begin
							add_at_start(K_DOT, 1);
							lx_state = S_IDLE; again = 1;
						end
					S_DOT2: begin
						if (c == ".") add_at_start(K_DOT3, 3);
						else begin
							add_at_start(K_DOT2, 2);
							again = 1;
						end
						lx_state = S_IDLE;
					end
					default: begin
						lx_state = S_IDLE; again = 1;
					end
				endcase
			end
			if (!lx_halted) begin
				cur_off = sat1(cur_off);
				if (c == CH_LF) begin
					cur_line = sat1(cur_line);
					cur_col = 0;
				end else cur_col = sat1(cur_col);
				if (after) begin
					tok_off = cur_off; tok_line = cur_line; tok_col = cur_col;
				end
			end
		end
		if (n_out > 0)
			token_q[token_q.size() - 1].last = 1;
	endtask

	// stimulus helpers
	task automatic put_text(input string s);
		text_item_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.mode = 0;
			t.code = s[i];
			text_q.push_back(t);
		end
	endtask

	task automatic put_byte(input logic [7:0] b);
		text_item_t t;
		t.mode = 0;
		t.code = b;
		text_q.push_back(t);
	endtask

	task automatic put_eot();
		text_item_t t;
		t.mode = 1;
		t.code = $urandom_range(0, 255);
		text_q.push_back(t);
	endtask

	function automatic string rand_word(input int n, input bit digits_only);
		string s, pool;
		int j;
		s = "";
		pool = digits_only ? "0123456789" : "abcxyzABZ_09q";
		for (int i = 0; i < n; i++) begin
			j = $urandom_range(0, pool.len() - 1);
			s = {s, pool.substr(j, j)};
		end
		return s;
	endfunction

	task automatic put_random_fragment();
		string ops;
		logic [7:0] b;
		int j;
		ops = "+*%:;,()[]{}#<>=-!&|/.";
		j = $urandom_range(0, ops.len() - 1);
		case ($urandom_range(0, 19))
			0, 1: put_text({"v", rand_word($urandom_range(0, 5), 0)});
			2: put_text(rand_word($urandom_range(1, 4), 1));
			3: put_text({rand_word(1, 1), ".", rand_word($urandom_range(0, 3), 1)});
			4: put_text({"0x", rand_word($urandom_range(0, 4), 0)});
			5: put_text({rand_word(1, 1), "..", rand_word(1, 1)});
			6: put_text({"\"", rand_word($urandom_range(0, 4), 0), "\\\""});
			7: put_text({"'", rand_word($urandom_range(0, 2), 0), "'"});
			8, 9, 10: put_text(ops.substr(j, j));
			11: put_text({"// ", rand_word($urandom_range(0, 4), 0), "\n"});
			12: put_text(" ");
			13: put_byte(CH_LF);
			14: put_byte($urandom_range(0, 1) ? CH_TAB : CH_CR);
			15: put_text("...");
			16: put_text({rand_word(1, 1), ".", rand_word(1, 1), ".", rand_word(1, 1)});
			17: put_byte($urandom_range(0, 255));
			18: begin
				b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255));
				if ($urandom_range(0, 3) == 0) put_byte(b);
				else put_text("0");
			end
			default: put_text(" ");
		endcase
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			mode <= 0;
			char_code <= 0;
			push_wait <= 0;
		end else begin
			if (push && !full) begin
				tokenize(mode, char_code);
				push_wait <= no_idle ? 0 : $urandom_range(0, 7);
				if (!no_idle && $urandom_range(0, 7) != 0) begin
					push <= 0;
				end else if (text_q.size() > 0) begin
					mode <= text_q[0].mode;
					char_code <= text_q[0].code;
					void'(text_q.pop_front());
				end else begin
					push <= 0;
				end
			end else if (!push) begin
				if (push_wait > 0) begin
					push_wait <= push_wait - 1;
				end else if (text_q.size() > 0) begin
					push <= 1;
					mode <= text_q[0].mode;
					char_code <= text_q[0].code;
					void'(text_q.pop_front());
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
			pop_wait <= 0;
		end else begin
			if (pop && !empty) begin
				if (token_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: kind %0d off %0d err %0d",
							lex_kind, start_offset, error_code);
				end else begin
					if (lex_kind !== token_q[0].lex_kind ||
							start_offset !== token_q[0].start_offset ||
							start_line !== token_q[0].start_line ||
							start_column !== token_q[0].start_column ||
							lex_length !== token_q[0].lex_length ||
							error_code !== token_q[0].error_code ||
							last !== token_q[0].last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind %0d off %0d line %0d col %0d len %0d",
								" err %0d last %0d / got %0d %0d %0d %0d %0d %0d %0d"},
								token_q[0].lex_kind, token_q[0].start_offset,
								token_q[0].start_line, token_q[0].start_column,
								token_q[0].lex_length, token_q[0].error_code,
								token_q[0].last, lex_kind, start_offset, start_line,
								start_column, lex_length, error_code, last);
					end
					void'(token_q.pop_front());
				end
				if (no_idle || $urandom_range(0, 7) == 0) begin
					pop_wait <= 0;
				end else begin
					pop_wait <= $urandom_range(1, 7);
					pop <= 0;
				end
			end else if (pop_wait > 0) begin
				pop_wait <= pop_wait - 1;
				pop <= (pop_wait == 1);
			end else begin
				pop <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int quiet;
		lexer_reset();
		arst_n = 0;
		// directed: every token kind, errors, flush cases
		put_text("a_9 0x1F 2.5 1..2 \"a\\\" '' <= < >= > == = -> - != ! && & || | / . .. ...");
		put_text("+*%:;,()[]{}#//c\n\t"); put_byte(CH_CR);
		put_text("7"); put_eot();
		put_text("1.2.3"); put_eot();
		put_text("0x;"); put_eot();
		put_text("\"ab"); put_eot();
		put_text("'"); put_eot();
		put_text("0x"); put_eot();
		put_text("1.2."); put_eot();
		put_text("//z"); put_eot();
		put_text(".."); put_eot();
		put_text("<"); put_eot();
		put_text("@q"); put_eot();
		put_byte(8'h00); put_eot();
		put_byte(8'hFF); put_eot();
		while (text_q.size() < 1350) begin
			for (int i = $urandom_range(3, 30); i > 0; i--)
				put_random_fragment();
			if ($urandom_range(0, 2) == 0) put_eot();
		end
		put_eot();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		while (text_q.size() > 0 || push) begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
		end
		while (token_q.size() > 0) @(negedge clk);
		quiet = 0;
		while (quiet < 10) begin
			@(posedge clk);
			quiet++;
		end
		if (mismatches == 0 && token_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
